// ----- hw/rtl/quaternion_normalize_to_rotation_macros.svh -----
// ----------------------------------------------------------------------------
// Quaternion to rotation assertion macros
// Concurrent assertion helpers used by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_NORMALIZE_TO_ROTATION_MACROS_SVH
`define QUATERNION_NORMALIZE_TO_ROTATION_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define QNR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define QNR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define QNR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QNR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/qnr_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion to rotation package
// Iteration counts, pipeline stage map, product slots, row codes and the pipeline payload type.
// ----------------------------------------------------------------------------
`default_nettype none

package qnr_pkg;

	// Square root and divider iterations, iterations per pipeline stage and stage counts.
	localparam int SqrtIters  = 17;
	localparam int SqrtPer    = 3;
	localparam int SqrtStages = 6;
	localparam int DivIters   = 15;
	localparam int DivPer     = 3;
	localparam int DivStages  = 5;

	// Stage map.
	localparam int StIn      = 0;
	localparam int StSq      = 1;
	localparam int StSum     = 2;
	localparam int StSqrt0   = 3;
	localparam int StDiv0    = StSqrt0 + SqrtStages;
	localparam int StUnit    = StDiv0 + DivStages;
	localparam int StMul     = StUnit + 1;
	localparam int StEnt     = StMul + 1;
	localparam int NumStages = StEnt + 1;

	// Product slots.
	localparam int PWW = 0;
	localparam int PXX = 1;
	localparam int PYY = 2;
	localparam int PZZ = 3;
	localparam int PXY = 4;
	localparam int PWZ = 5;
	localparam int PXZ = 6;
	localparam int PWY = 7;
	localparam int PYZ = 8;
	localparam int PWX = 9;

	// Row codes.
	localparam logic [1:0] RowFirst = 2'd0;
	localparam logic [1:0] RowMid   = 2'd1;
	localparam logic [1:0] RowLast  = 2'd2;

	typedef struct packed {
		logic [3:0][15:0] c;
		logic [3:0][15:0] a;
		logic             norm;
		logic [3:0][30:0] sq;
		logic [33:0]      rad;
		logic [19:0]      rem;
		logic [16:0]      root;
		logic [3:0][17:0] drem;
		logic [3:0][14:0] quo;
		logic             zero;
		logic [3:0][15:0] u;
		logic [9:0][31:0] prod;
		logic [8:0][19:0] e;
	} pipe_t;

endpackage

`default_nettype wire

// ----- hw/rtl/quaternion_normalize_to_rotation.sv -----
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix
// Magnitude, unit quaternion and 3x3 rotation matrix in fixed point.
// ----------------------------------------------------------------------------
// A quaternion transaction enters a 17-stage pipeline (squares, sum, a
// six-stage square root, a five-stage divider for all four components,
// then the products and the matrix entries) and comes out as three row
// transactions, row 0 to row 2, one per cycle while row_ready is high.
// The result port limits the sustained rate, since each quaternion is
// delivered as three row transactions; the pipeline keeps taking
// quaternions while a finished one is still being delivered.
`default_nettype none

`include "quaternion_normalize_to_rotation_macros.svh"

module quaternion_normalize_to_rotation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic signed [15:0] comp_w,
	input  logic signed [15:0] comp_x,
	input  logic signed [15:0] comp_y,
	input  logic signed [15:0] comp_z,
	input  logic               normalize_first,
	output logic               row_valid,
	input  logic               row_ready,
	output logic [1:0]         row_index,
	output logic signed [19:0] col_first,
	output logic signed [19:0] col_second,
	output logic signed [19:0] col_third,
	output logic signed [15:0] unit_w,
	output logic signed [15:0] unit_x,
	output logic signed [15:0] unit_y,
	output logic signed [15:0] unit_z,
	output logic [15:0]        length,
	output logic               zero_length,
	output logic               last_row
);

	localparam int Last = qnr_pkg::NumStages - 1;

	// One matrix entry: floor((p1 +/- p2) / 2^13), less 1.0 on the diagonal.
	function automatic logic [19:0] entry_f(logic [31:0] p1, logic [31:0] p2,
			logic neg, logic diag);
		logic signed [32:0] s;
		logic signed [20:0] q;
		if (neg) begin
			s = $signed({p1[31], p1}) - $signed({p2[31], p2});
		end else begin
			s = $signed({p1[31], p1}) + $signed({p2[31], p2});
		end
		q = {s[32], s[32:13]};
		if (diag) begin
			q = q - 21'sd16384;
		end
		if (q[20] != q[19]) begin
			return q[20] ? 20'h80000 : 20'h7FFFF;
		end
		return q[19:0];
	endfunction

	// Work done by one stage on the payload of the stage before it.
	function automatic qnr_pkg::pipe_t stage_f(int k, qnr_pkg::pipe_t p);
		qnr_pkg::pipe_t     n;
		logic [19:0]        r2;
		logic [19:0]        tr;
		logic [17:0]        d2;
		logic               nb;
		int                 it;
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		n = p;
		case (k) inside
			qnr_pkg::StSq: begin
				for (int i = 0; i < 4; i++) begin
					n.sq[i] = 31'(32'(p.a[i]) * 32'(p.a[i]));
				end
			end
			qnr_pkg::StSum: begin
				n.rad  = {1'b0, 33'(p.sq[0]) + 33'(p.sq[1]) + 33'(p.sq[2]) + 33'(p.sq[3])};
				n.rem  = '0;
				n.root = '0;
			end
			[qnr_pkg::StSqrt0:qnr_pkg::StDiv0 - 1]: begin
				// Digit-by-digit square root, one result bit per step.
				for (int t = 0; t < qnr_pkg::SqrtPer; t++) begin
					it = (k - qnr_pkg::StSqrt0) * qnr_pkg::SqrtPer + t;
					if (it < qnr_pkg::SqrtIters) begin
						r2 = {n.rem[17:0], n.rad[33:32]};
						tr = {1'b0, n.root, 2'b01};
						if (r2 >= tr) begin
							n.rem  = r2 - tr;
							n.root = {n.root[15:0], 1'b1};
						end else begin
							n.rem  = r2;
							n.root = {n.root[15:0], 1'b0};
						end
						n.rad = {n.rad[31:0], 2'b00};
					end
				end
			end
			[qnr_pkg::StDiv0:qnr_pkg::StUnit - 1]: begin
				// Restoring division of |c| * 2^14 by the magnitude.
				if (k == qnr_pkg::StDiv0) begin
					for (int i = 0; i < 4; i++) begin
						n.drem[i] = {3'b000, p.a[i][15:1]};
						n.quo[i]  = '0;
					end
				end
				for (int t = 0; t < qnr_pkg::DivPer; t++) begin
					it = (k - qnr_pkg::StDiv0) * qnr_pkg::DivPer + t;
					if (it < qnr_pkg::DivIters) begin
						for (int i = 0; i < 4; i++) begin
							nb = (it == 0) ? p.a[i][0] : 1'b0;
							d2 = {n.drem[i][16:0], nb};
							if (d2 >= {1'b0, n.root}) begin
								n.drem[i] = d2 - {1'b0, n.root};
								n.quo[i]  = {n.quo[i][13:0], 1'b1};
							end else begin
								n.drem[i] = d2;
								n.quo[i]  = {n.quo[i][13:0], 1'b0};
							end
						end
					end
				end
			end
			qnr_pkg::StUnit: begin
				n.zero = (p.root == '0);
				for (int i = 0; i < 4; i++) begin
					if (n.zero) begin
						n.u[i] = '0;
					end else if (p.c[i][15]) begin
						n.u[i] = 16'd0 - {1'b0, p.quo[i]};
					end else begin
						n.u[i] = {1'b0, p.quo[i]};
					end
				end
			end
			qnr_pkg::StMul: begin
				w = $signed(p.norm ? p.u[0] : p.c[0]);
				x = $signed(p.norm ? p.u[1] : p.c[1]);
				y = $signed(p.norm ? p.u[2] : p.c[2]);
				z = $signed(p.norm ? p.u[3] : p.c[3]);
				n.prod[qnr_pkg::PWW] = 32'(w * w);
				n.prod[qnr_pkg::PXX] = 32'(x * x);
				n.prod[qnr_pkg::PYY] = 32'(y * y);
				n.prod[qnr_pkg::PZZ] = 32'(z * z);
				n.prod[qnr_pkg::PXY] = 32'(x * y);
				n.prod[qnr_pkg::PWZ] = 32'(w * z);
				n.prod[qnr_pkg::PXZ] = 32'(x * z);
				n.prod[qnr_pkg::PWY] = 32'(w * y);
				n.prod[qnr_pkg::PYZ] = 32'(y * z);
				n.prod[qnr_pkg::PWX] = 32'(w * x);
			end
			qnr_pkg::StEnt: begin
				n.e[0] = entry_f(p.prod[qnr_pkg::PWW], p.prod[qnr_pkg::PXX], 1'b0, 1'b1);
				n.e[1] = entry_f(p.prod[qnr_pkg::PXY], p.prod[qnr_pkg::PWZ], 1'b1, 1'b0);
				n.e[2] = entry_f(p.prod[qnr_pkg::PXZ], p.prod[qnr_pkg::PWY], 1'b0, 1'b0);
				n.e[3] = entry_f(p.prod[qnr_pkg::PXY], p.prod[qnr_pkg::PWZ], 1'b0, 1'b0);
				n.e[4] = entry_f(p.prod[qnr_pkg::PWW], p.prod[qnr_pkg::PYY], 1'b0, 1'b1);
				n.e[5] = entry_f(p.prod[qnr_pkg::PYZ], p.prod[qnr_pkg::PWX], 1'b1, 1'b0);
				n.e[6] = entry_f(p.prod[qnr_pkg::PXZ], p.prod[qnr_pkg::PWY], 1'b1, 1'b0);
				n.e[7] = entry_f(p.prod[qnr_pkg::PYZ], p.prod[qnr_pkg::PWX], 1'b0, 1'b0);
				n.e[8] = entry_f(p.prod[qnr_pkg::PWW], p.prod[qnr_pkg::PZZ], 1'b0, 1'b1);
			end
			default: begin
			end
		endcase
		return n;
	endfunction

	qnr_pkg::pipe_t               pl_s [qnr_pkg::NumStages];
	qnr_pkg::pipe_t               nx [qnr_pkg::NumStages];
	logic [qnr_pkg::NumStages-1:0] vld_s;
	logic [qnr_pkg::NumStages:0]   en;
	qnr_pkg::pipe_t               out_q;
	logic                         out_vld_q;
	logic [1:0]                   row_q;
	logic                         take;

	// Next payloads: raw inputs and magnitudes, then each stage's work.
	always_comb begin
		nx[0]      = '0;
		nx[0].c[0] = comp_w;
		nx[0].c[1] = comp_x;
		nx[0].c[2] = comp_y;
		nx[0].c[3] = comp_z;
		for (int i = 0; i < 4; i++) begin
			nx[0].a[i] = nx[0].c[i][15] ? 16'd0 - nx[0].c[i] : nx[0].c[i];
		end
		nx[0].norm = normalize_first;
		for (int k = 1; k < qnr_pkg::NumStages; k++) begin
			nx[k] = stage_f(k, pl_s[k-1]);
		end
	end

	// A stage loads when it is empty or the stage after it moves on.
	always_comb begin
		take = !out_vld_q || (row_ready && row_q == qnr_pkg::RowLast);
		en[qnr_pkg::NumStages] = take;
		for (int k = qnr_pkg::NumStages - 1; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign item_ready = en[0];

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= item_valid;
			end
			for (int k = 1; k < qnr_pkg::NumStages; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		for (int k = 0; k < qnr_pkg::NumStages; k++) begin
			if (en[k]) begin
				pl_s[k] <= nx[k];
			end
		end
	end

	// Output buffer control: three row transactions per quaternion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			row_q     <= qnr_pkg::RowFirst;
		end else if (take) begin
			out_vld_q <= vld_s[Last];
			row_q     <= qnr_pkg::RowFirst;
		end else if (row_ready) begin
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= pl_s[Last];
		end
	end

	// Row selection and output fields.
	always_comb begin
		case (row_q)
			qnr_pkg::RowFirst: begin
				col_first  = out_q.e[0];
				col_second = out_q.e[1];
				col_third  = out_q.e[2];
			end
			qnr_pkg::RowMid: begin
				col_first  = out_q.e[3];
				col_second = out_q.e[4];
				col_third  = out_q.e[5];
			end
			default: begin
				col_first  = out_q.e[6];
				col_second = out_q.e[7];
				col_third  = out_q.e[8];
			end
		endcase
	end

	assign row_valid   = out_vld_q;
	assign row_index   = row_q;
	assign last_row    = (row_q == qnr_pkg::RowLast);
	assign unit_w      = out_q.u[0];
	assign unit_x      = out_q.u[1];
	assign unit_y      = out_q.u[2];
	assign unit_z      = out_q.u[3];
	assign length      = out_q.root[16] ? 16'hFFFF : out_q.root[15:0];
	assign zero_length = out_q.zero;

	// A zero magnitude gives a zero unit quaternion.
	`QNR_ASSERT_IMP(a_zero_unit, clk, arst_n, row_valid && zero_length,
		unit_w == 16'd0 && unit_x == 16'd0 && unit_y == 16'd0 && unit_z == 16'd0)
	// The zero flag and the magnitude agree.
	`QNR_ASSERT_IMP(a_zero_len, clk, arst_n, row_valid, zero_length == (length == 16'd0))
	// After an early row is taken, the same quaternion offers its next row.
	`QNR_ASSERT_NEXT(a_row_run, clk, arst_n, row_valid && row_ready && !last_row,
		row_valid && $stable(length) && $stable(unit_w))
	// The pipeline never accepts while its input stage is full and stalled.
	`QNR_ASSERT_IMP(a_no_overrun, clk, arst_n, vld_s[0] && !en[1], !item_ready)

endmodule

`default_nettype wire
